// File: rtl/vsnu_pkg.sv
// ----------------------------------------------------------------------------
// vsnu_pkg: shared types and constants of the vorticity stencil node unit
// Operation codes, register map, datapath widths and the item layout.
// ----------------------------------------------------------------------------
package vsnu_pkg;

    localparam int FRAC_BITS = 16;            // fractional bits of the Q format
    localparam int W         = 32;            // width of every data field
    localparam int DW1       = W + 1;         // first difference
    localparam int DW2       = W + 3;         // second difference E - 2M + W
    localparam int PW        = DW2 + W;       // second difference times gain
    localparam int JPW       = 2 * DW1;       // one Jacobian product
    localparam int JW        = JPW + 1;       // Jacobian
    localparam int JQW       = JW - FRAC_BITS; // Jacobian after the first rounding
    localparam int JQ_HI_W   = 34;            // signed upper part of the Jacobian
    localparam int JQ_LO_W   = JQW - JQ_HI_W; // unsigned lower part
    localparam int PHW       = JQ_HI_W + W;   // upper partial product
    localparam int PLW       = JQ_LO_W + 1 + W; // lower partial product
    localparam int WPW       = DW1 + W;       // wall product
    localparam int AW        = JQW + W + 1;   // accumulator
    localparam int RW        = AW - FRAC_BITS; // accumulator after rounding
    localparam int NUM_STAGES = 6;

    localparam int OP_W   = 3;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_LAPLACIAN = 3'd0,
        OP_ADVANCE   = 3'd1,
        OP_XWALL     = 3'd2,
        OP_YWALL     = 3'd3,
        OP_LID       = 3'd4
    } op_t;

    localparam logic [IDX_W-1:0] REG_INV_DX_SQ  = 3'd0;
    localparam logic [IDX_W-1:0] REG_INV_DY_SQ  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ADVECT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIFFUSE_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIFFUSE_Y  = 3'd4;
    localparam logic [IDX_W-1:0] REG_LID        = 3'd5;

    localparam logic signed [W-1:0] ONE_Q = W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [W-1:0] TWO_Q = W'(64'sd2 <<< FRAC_BITS);

    typedef struct packed {
        logic signed [W-1:0] inv_dx_sq;
        logic signed [W-1:0] inv_dy_sq;
        logic signed [W-1:0] advect_gain;
        logic signed [W-1:0] diffuse_gain_x;
        logic signed [W-1:0] diffuse_gain_y;
        logic signed [W-1:0] lid_term;
    } cfg_t;

    // first member lands in the highest bits: psi_mid ends up at the bottom
    typedef struct packed {
        logic signed [W-1:0] omega_north;
        logic signed [W-1:0] omega_south;
        logic signed [W-1:0] omega_east;
        logic signed [W-1:0] omega_west;
        logic signed [W-1:0] omega_mid;
        logic signed [W-1:0] psi_north;
        logic signed [W-1:0] psi_south;
        logic signed [W-1:0] psi_east;
        logic signed [W-1:0] psi_west;
        logic signed [W-1:0] psi_mid;
    } item_t;

endpackage

// File: rtl/vsnu_datapath.sv
// ----------------------------------------------------------------------------
// vsnu_datapath: six-stage arithmetic pipeline of the node update
// Differences, products, combination, split advection product, sum, saturate.
// ----------------------------------------------------------------------------
module vsnu_datapath (
    input  logic                                 clk,
    input  logic [vsnu_pkg::NUM_STAGES-1:0]      stage_en,
    input  vsnu_pkg::cfg_t                       cfg,
    input  logic [vsnu_pkg::OP_W-1:0]            operation,
    input  vsnu_pkg::item_t                      item,
    output logic signed [vsnu_pkg::W-1:0]        node_value,
    output logic                                 saturated
);

    // stage 1: differences
    logic [vsnu_pkg::OP_W-1:0]             op1_reg;
    logic signed [vsnu_pkg::DW2-1:0]       d2x_psi_reg, d2y_psi_reg;
    logic signed [vsnu_pkg::DW2-1:0]       d2x_om_reg, d2y_om_reg;
    logic signed [vsnu_pkg::DW1-1:0]       dns_psi_reg, dew_psi_reg;
    logic signed [vsnu_pkg::DW1-1:0]       dns_om_reg, dew_om_reg;
    logic signed [vsnu_pkg::DW1-1:0]       dwall_reg;
    logic signed [vsnu_pkg::W-1:0]         om1_reg;

    // stage 2: products
    logic [vsnu_pkg::OP_W-1:0]             op2_reg;
    logic signed [vsnu_pkg::W-1:0]         om2_reg;
    logic signed [vsnu_pkg::PW-1:0]        prod_a_reg, prod_b_reg;
    logic signed [vsnu_pkg::JPW-1:0]       jac_a_reg, jac_b_reg;
    logic signed [vsnu_pkg::WPW-1:0]       wall_reg;

    // stage 3: combination
    logic signed [vsnu_pkg::AW-1:0]        base3_reg;
    logic signed [vsnu_pkg::JQW-1:0]       jq_reg;

    // stage 4: advection partial products
    logic signed [vsnu_pkg::AW-1:0]        base4_reg;
    logic signed [vsnu_pkg::PHW-1:0]       ph_reg;
    logic signed [vsnu_pkg::PLW-1:0]       pl_reg;

    // stage 5: sum
    logic signed [vsnu_pkg::AW-1:0]        acc_reg;

    // stage 6: output
    logic signed [vsnu_pkg::W-1:0]         node_value_reg;
    logic                                  saturated_reg;

    logic signed [vsnu_pkg::DW2-1:0]       mul_a_in, mul_b_in;
    logic signed [vsnu_pkg::W-1:0]         gain_a, gain_b, wall_gain;
    logic signed [vsnu_pkg::JW-1:0]        jac_diff;
    logic signed [vsnu_pkg::AW-1:0]        base_next;
    logic signed [vsnu_pkg::JQW-1:0]       jq_next;
    logic signed [vsnu_pkg::RW-1:0]        res;
    logic [vsnu_pkg::RW-vsnu_pkg::W:0]     res_top;
    logic signed [vsnu_pkg::W-1:0]         node_value_next;
    logic                                  saturated_next;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            op1_reg     <= operation;
            d2x_psi_reg <= vsnu_pkg::DW2'(item.psi_east) + vsnu_pkg::DW2'(item.psi_west)
                           - (vsnu_pkg::DW2'(item.psi_mid) <<< 1);
            d2y_psi_reg <= vsnu_pkg::DW2'(item.psi_north) + vsnu_pkg::DW2'(item.psi_south)
                           - (vsnu_pkg::DW2'(item.psi_mid) <<< 1);
            d2x_om_reg  <= vsnu_pkg::DW2'(item.omega_east) + vsnu_pkg::DW2'(item.omega_west)
                           - (vsnu_pkg::DW2'(item.omega_mid) <<< 1);
            d2y_om_reg  <= vsnu_pkg::DW2'(item.omega_north)
                           + vsnu_pkg::DW2'(item.omega_south)
                           - (vsnu_pkg::DW2'(item.omega_mid) <<< 1);
            dns_psi_reg <= vsnu_pkg::DW1'(item.psi_north) - vsnu_pkg::DW1'(item.psi_south);
            dew_psi_reg <= vsnu_pkg::DW1'(item.psi_east) - vsnu_pkg::DW1'(item.psi_west);
            dns_om_reg  <= vsnu_pkg::DW1'(item.omega_north) - vsnu_pkg::DW1'(item.omega_south);
            dew_om_reg  <= vsnu_pkg::DW1'(item.omega_east) - vsnu_pkg::DW1'(item.omega_west);
            dwall_reg   <= vsnu_pkg::DW1'(item.psi_mid) - vsnu_pkg::DW1'(item.psi_north);
            om1_reg     <= item.omega_mid;
        end
    end

    // share the two gain multipliers between Laplacian and diffusion
    always_comb
    begin
        if (op1_reg == vsnu_pkg::OP_ADVANCE)
        begin
            mul_a_in = d2x_om_reg;
            mul_b_in = d2y_om_reg;
            gain_a   = cfg.diffuse_gain_x;
            gain_b   = cfg.diffuse_gain_y;
        end
        else
        begin
            mul_a_in = d2x_psi_reg;
            mul_b_in = d2y_psi_reg;
            gain_a   = cfg.inv_dx_sq;
            gain_b   = cfg.inv_dy_sq;
        end
        wall_gain = (op1_reg == vsnu_pkg::OP_XWALL) ? cfg.inv_dx_sq : cfg.inv_dy_sq;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            op2_reg    <= op1_reg;
            om2_reg    <= om1_reg;
            prod_a_reg <= vsnu_pkg::PW'(mul_a_in) * vsnu_pkg::PW'(gain_a);
            prod_b_reg <= vsnu_pkg::PW'(mul_b_in) * vsnu_pkg::PW'(gain_b);
            jac_a_reg  <= vsnu_pkg::JPW'(dns_psi_reg) * vsnu_pkg::JPW'(dew_om_reg);
            jac_b_reg  <= vsnu_pkg::JPW'(dew_psi_reg) * vsnu_pkg::JPW'(dns_om_reg);
            wall_reg   <= vsnu_pkg::WPW'(dwall_reg) * vsnu_pkg::WPW'(wall_gain);
        end
    end

    always_comb
    begin
        jac_diff = vsnu_pkg::JW'(jac_a_reg) - vsnu_pkg::JW'(jac_b_reg);
        jq_next  = '0;
        case (op2_reg)
            vsnu_pkg::OP_LAPLACIAN:
            begin
                base_next = -(vsnu_pkg::AW'(prod_a_reg) + vsnu_pkg::AW'(prod_b_reg));
            end
            vsnu_pkg::OP_ADVANCE:
            begin
                base_next = (vsnu_pkg::AW'(om2_reg) <<< vsnu_pkg::FRAC_BITS)
                            + vsnu_pkg::AW'(prod_a_reg) + vsnu_pkg::AW'(prod_b_reg);
                jq_next   = vsnu_pkg::JQW'(jac_diff >>> vsnu_pkg::FRAC_BITS);
            end
            vsnu_pkg::OP_XWALL, vsnu_pkg::OP_YWALL:
            begin
                base_next = vsnu_pkg::AW'(wall_reg) <<< 1;
            end
            vsnu_pkg::OP_LID:
            begin
                base_next = (vsnu_pkg::AW'(wall_reg) <<< 1)
                            - (vsnu_pkg::AW'(cfg.lid_term) <<< vsnu_pkg::FRAC_BITS);
            end
            default:
            begin
                base_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            base3_reg <= base_next;
            jq_reg    <= jq_next;
        end
    end

    // split the wide Jacobian so that each multiplier stays near 32 by 32
    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            base4_reg <= base3_reg;
            ph_reg    <= vsnu_pkg::PHW'($signed(jq_reg[vsnu_pkg::JQW-1:vsnu_pkg::JQ_LO_W]))
                         * vsnu_pkg::PHW'(cfg.advect_gain);
            pl_reg    <= vsnu_pkg::PLW'($signed({1'b0, jq_reg[vsnu_pkg::JQ_LO_W-1:0]}))
                         * vsnu_pkg::PLW'(cfg.advect_gain);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            acc_reg <= base4_reg + (vsnu_pkg::AW'(ph_reg) <<< vsnu_pkg::JQ_LO_W)
                       + vsnu_pkg::AW'(pl_reg);
        end
    end

    // floor by arithmetic shift, then clip to the 32-bit range
    always_comb
    begin
        res     = vsnu_pkg::RW'(acc_reg >>> vsnu_pkg::FRAC_BITS);
        res_top = res[vsnu_pkg::RW-1:vsnu_pkg::W-1];
        if ((&res_top) || !(|res_top))
        begin
            node_value_next = res[vsnu_pkg::W-1:0];
            saturated_next  = 1'b0;
        end
        else
        begin
            node_value_next = res[vsnu_pkg::RW-1] ? {1'b1, {(vsnu_pkg::W-1){1'b0}}}
                                                  : {1'b0, {(vsnu_pkg::W-1){1'b1}}};
            saturated_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            node_value_reg <= node_value_next;
            saturated_reg  <= saturated_next;
        end
    end

    assign node_value = node_value_reg;
    assign saturated  = saturated_reg;

endmodule

// File: rtl/vorticity_stencil_node_update_unit.sv
// An accepted item passes through six register stages, each with its own valid
// bit, to the master side. Throughput: one item per cycle unless the master stalls.
// A stall on the master side holds only the full stages; empty stages keep filling.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// register defaults: inv_dx_sq = inv_dy_sq = 1.0, lid_term = 2.0, gains 0.
// ----------------------------------------------------------------------------
// vorticity_stencil_node_update_unit: vorticity-streamfunction node kernel
// Stream in a five-point neighbourhood, stream out one saturated node value.
// ----------------------------------------------------------------------------
module vorticity_stencil_node_update_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vsnu_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // psi_mid, psi_west, psi_east, psi_south, psi_north,
    // omega_mid, omega_west, omega_east, omega_south, omega_north (32 bits each)
    input  logic [319:0]                     s_tdata,
    // operation [2:0]
    input  logic [2:0]                       s_tuser,
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // node_value [31:0]
    output logic [31:0]                      m_tdata,
    // saturated [0]
    output logic                             m_tuser
);

    vsnu_pkg::cfg_t                          cfg_reg;
    logic [vsnu_pkg::NUM_STAGES-1:0]         valid_reg;
    logic [vsnu_pkg::NUM_STAGES-1:0]         stage_en;
    logic [vsnu_pkg::IDX_W-1:0]              reg_idx;
    logic                                    cfg_write;
    logic signed [vsnu_pkg::W-1:0]           node_value;
    logic                                    saturated;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[vsnu_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_dx_sq      <= vsnu_pkg::ONE_Q;
            cfg_reg.inv_dy_sq      <= vsnu_pkg::ONE_Q;
            cfg_reg.advect_gain    <= '0;
            cfg_reg.diffuse_gain_x <= '0;
            cfg_reg.diffuse_gain_y <= '0;
            cfg_reg.lid_term       <= vsnu_pkg::TWO_Q;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                vsnu_pkg::REG_INV_DX_SQ: cfg_reg.inv_dx_sq      <= pwdata;
                vsnu_pkg::REG_INV_DY_SQ: cfg_reg.inv_dy_sq      <= pwdata;
                vsnu_pkg::REG_ADVECT:    cfg_reg.advect_gain    <= pwdata;
                vsnu_pkg::REG_DIFFUSE_X: cfg_reg.diffuse_gain_x <= pwdata;
                vsnu_pkg::REG_DIFFUSE_Y: cfg_reg.diffuse_gain_y <= pwdata;
                vsnu_pkg::REG_LID:       cfg_reg.lid_term       <= pwdata;
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            vsnu_pkg::REG_INV_DX_SQ: prdata = cfg_reg.inv_dx_sq;
            vsnu_pkg::REG_INV_DY_SQ: prdata = cfg_reg.inv_dy_sq;
            vsnu_pkg::REG_ADVECT:    prdata = cfg_reg.advect_gain;
            vsnu_pkg::REG_DIFFUSE_X: prdata = cfg_reg.diffuse_gain_x;
            vsnu_pkg::REG_DIFFUSE_Y: prdata = cfg_reg.diffuse_gain_y;
            vsnu_pkg::REG_LID:       prdata = cfg_reg.lid_term;
            default:                 prdata = '0;
        endcase
    end

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        stage_en[vsnu_pkg::NUM_STAGES-1] = !valid_reg[vsnu_pkg::NUM_STAGES-1] || m_tready;
        for (int k = vsnu_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < vsnu_pkg::NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[vsnu_pkg::NUM_STAGES-1];

    vsnu_datapath u_datapath (
        .clk        (clk),
        .stage_en   (stage_en),
        .cfg        (cfg_reg),
        .operation  (s_tuser),
        .item       (vsnu_pkg::item_t'(s_tdata)),
        .node_value (node_value),
        .saturated  (saturated)
    );

    assign m_tdata = node_value;
    assign m_tuser = saturated;

endmodule

// File: tb/vsnu_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vsnu_stream_checker: result checker for the vorticity stencil node unit
// Tracks the register port, predicts the node value of every accepted item
// from its own register copy and compares the result stream in order.
// ----------------------------------------------------------------------------
module vsnu_stream_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vsnu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    // psi_mid, psi_west, psi_east, psi_south, psi_north,
    // omega_mid, omega_west, omega_east, omega_south, omega_north (32 bits each)
    input  logic [319:0]                s_tdata,
    // operation [2:0]
    input  logic [2:0]                  s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    // node_value [31:0]
    input  logic [31:0]                 m_tdata,
    // saturated [0]
    input  logic                        m_tuser,
    output int unsigned                 fail_count,
    output int unsigned                 results_pending,
    output int unsigned                 results_checked,
    output int unsigned                 saturated_seen
);
    import vsnu_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [W-1:0] node_value;
        logic         saturated;
    } node_result_t;

    localparam wide_t Q_MAX = 128'sh7FFF_FFFF;
    localparam wide_t Q_MIN = -128'sh8000_0000;

    wide_t        inv_dx, inv_dy, advect, diff_x, diff_y, lid;
    node_result_t node_expect_q[$];
    int unsigned  mismatches, checked, clipped;

    function automatic node_result_t predict_node(input logic [OP_W-1:0] op, input item_t n);
        wide_t        p_m, p_w, p_e, p_s, p_n, w_m, w_w, w_e, w_s, w_n;
        wide_t        acc, jac, wall;
        node_result_t res;
        p_m = $signed(n.psi_mid);
        p_w = $signed(n.psi_west);
        p_e = $signed(n.psi_east);
        p_s = $signed(n.psi_south);
        p_n = $signed(n.psi_north);
        w_m = $signed(n.omega_mid);
        w_w = $signed(n.omega_west);
        w_e = $signed(n.omega_east);
        w_s = $signed(n.omega_south);
        w_n = $signed(n.omega_north);
        res = '0;
        acc = '0;
        case (op)
            OP_LAPLACIAN:
                acc = -((p_e - 2 * p_m + p_w) * inv_dx + (p_n - 2 * p_m + p_s) * inv_dy);
            OP_ADVANCE:
            begin
                // the Jacobian is rounded down once before the gain is applied
                jac = (p_n - p_s) * (w_e - w_w) - (p_e - p_w) * (w_n - w_s);
                acc = (w_m <<< FRAC_BITS) + (jac >>> FRAC_BITS) * advect
                    + (w_e - 2 * w_m + w_w) * diff_x + (w_n - 2 * w_m + w_s) * diff_y;
            end
            OP_XWALL, OP_YWALL, OP_LID:
            begin
                wall = (p_m - p_n) * ((op == OP_XWALL) ? inv_dx : inv_dy);
                acc  = 2 * wall;
                if (op == OP_LID)
                    acc = acc - (lid <<< FRAC_BITS);
            end
            default:
                return res;
        endcase
        acc = acc >>> FRAC_BITS;
        if (acc > Q_MAX)
        begin
            res.node_value = Q_MAX[W-1:0];
            res.saturated  = 1'b1;
        end
        else if (acc < Q_MIN)
        begin
            res.node_value = Q_MIN[W-1:0];
            res.saturated  = 1'b1;
        end
        else
            res.node_value = acc[W-1:0];
        return res;
    endfunction

    function automatic logic [31:0] register_value(input logic [IDX_W-1:0] idx);
        case (idx)
            REG_INV_DX_SQ: return inv_dx[31:0];
            REG_INV_DY_SQ: return inv_dy[31:0];
            REG_ADVECT:    return advect[31:0];
            REG_DIFFUSE_X: return diff_x[31:0];
            REG_DIFFUSE_Y: return diff_y[31:0];
            default:       return lid[31:0];
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        node_result_t want;
        logic [IDX_W-1:0] idx;
        if (!rst_n)
        begin
            inv_dx = $signed(ONE_Q);
            inv_dy = $signed(ONE_Q);
            advect = '0;
            diff_x = '0;
            diff_y = '0;
            lid    = $signed(TWO_Q);
            node_expect_q.delete();
            mismatches = 0;
            checked    = 0;
            clipped    = 0;
            fail_count      <= 0;
            results_pending <= 0;
            results_checked <= 0;
            saturated_seen  <= 0;
        end
        else
        begin
            idx = paddr[ADDR_W-1:2];
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (idx)
                        REG_INV_DX_SQ: inv_dx = $signed(pwdata);
                        REG_INV_DY_SQ: inv_dy = $signed(pwdata);
                        REG_ADVECT:    advect = $signed(pwdata);
                        REG_DIFFUSE_X: diff_x = $signed(pwdata);
                        REG_DIFFUSE_Y: diff_y = $signed(pwdata);
                        REG_LID:       lid    = $signed(pwdata);
                        default: ;
                    endcase
                end
                else if (idx <= REG_LID && prdata !== register_value(idx))
                begin
                    mismatches++;
                    $error("register %0d: expected %h, actual %h",
                           idx, register_value(idx), prdata);
                end
            end

            // pop before push: a result never belongs to the item taken at the same edge
            if (m_tvalid && m_tready)
            begin
                if (node_expect_q.size() == 0)
                begin
                    mismatches++;
                    $error("node result with no item outstanding: node_value %h saturated %b",
                           m_tdata, m_tuser);
                end
                else
                begin
                    want = node_expect_q.pop_front();
                    checked++;
                    if (want.saturated)
                        clipped++;
                    if (m_tdata !== want.node_value)
                    begin
                        mismatches++;
                        $error("node_value: expected %h, actual %h", want.node_value, m_tdata);
                    end
                    if (m_tuser !== want.saturated)
                    begin
                        mismatches++;
                        $error("saturated: expected %b, actual %b", want.saturated, m_tuser);
                    end
                end
            end

            if (s_tvalid && s_tready)
                node_expect_q.push_back(predict_node(s_tuser, item_t'(s_tdata)));

            fail_count      <= mismatches;
            results_pending <= node_expect_q.size();
            results_checked <= checked;
            saturated_seen  <= clipped;
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression for the vorticity stencil node update unit
// Streams directed corner cases and random stencil neighbourhoods through the
// unit under a series of register settings, with bursty input, a stalling
// result side and two long hold-offs; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
    import vsnu_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 130;
    localparam int HOLD_ITEMS   = 40;

    // settings that are not random
    localparam int PHASE_DEFAULT = 0;
    localparam int PHASE_TOP     = 1;
    localparam int PHASE_BOTTOM  = 2;
    localparam int PHASE_ZERO    = 3;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [W-1:0] Q_ONE = 32'h0001_0000;

    typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [319:0]        s_tdata;
    logic [2:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;
    logic                m_tuser;

    int unsigned fail_count, results_pending, results_checked, saturated_seen;
    int unsigned items_sent, directed_sent, settings_used, burst_left, cycles;
    bit          long_hold_req;

    vorticity_stencil_node_update_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    vsnu_stream_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .results_checked (results_checked),
        .saturated_seen  (saturated_seen)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, results_pending);
        $display("vorticity_stencil_node_update_unit regression: fail");
        $finish;
    end

    // result side: stall on a changing pattern, or hold off for a long stretch on request
    initial
    begin : receiver
        rx_mode_t    mode;
        int unsigned mode_left, hold;
        mode      = RX_FREE;
        mode_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = $urandom_range(150, 300);
                m_tready <= 1'b0;
                while (hold != 0)
                begin
                    @(posedge clk);
                    hold--;
                end
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(RX_FREE, RX_MOSTLY));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_HALF:   m_tready <= ($urandom_range(0, 1) == 0);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
                    default:   m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return '1;
            4:       return Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    // mostly smooth neighbourhoods, some wild ones and some built from corner values
    function automatic item_t random_node();
        logic [9:0][31:0] word;
        logic [31:0]      base;
        int unsigned      style, spread;
        style  = $urandom_range(0, 9);
        spread = 1 << $urandom_range(0, 20);
        base   = '0;
        for (int f = 0; f < 10; f++)
        begin
            if (f == 0 || f == 5)
                base = (style < 7) ? $urandom : $urandom_range(0, 32'h40_0000) - 32'h20_0000;
            if (style < 3)
                word[f] = $urandom;
            else if (style == 3)
                word[f] = corner_word();
            else
                word[f] = base + $urandom_range(0, 2 * spread) - spread;
        end
        return item_t'(word);
    endfunction

    function automatic logic [OP_W-1:0] random_op();
        if ($urandom_range(0, 19) == 0)
            return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        return OP_W'($urandom_range(OP_LAPLACIAN, OP_LID));
    endfunction

    function automatic logic [31:0] random_setting(input int idx);
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        if (idx == REG_INV_DX_SQ || idx == REG_INV_DY_SQ)
            return $urandom_range(32'h4000, 32'h40_0000);
        if (idx == REG_LID)
            return $urandom_range(0, 32'h10_0000) - 32'h8_0000;
        return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
    endfunction

    function automatic item_t node_of(input logic [31:0] pm, pw, pe, ps, pn,
                                      input logic [31:0] wm, ww, we, ws, wn);
        return {wn, ws, we, ww, wm, pn, ps, pe, pw, pm};
    endfunction

    task automatic reg_access(input bit is_write, input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {IDX_W'(idx), 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // offer one item; steady items keep the valid up with no gap
    task automatic send_node(input logic [OP_W-1:0] op, input item_t node, input bit steady);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= node;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (!steady && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        else if (burst_left != 0)
            burst_left--;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
    endtask

    initial
    begin : stimulus
        logic [31:0] setting;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        long_hold_req = 1'b0;
        items_sent    = 0;
        directed_sent = 0;
        settings_used = 1;
        burst_left    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == PHASE_DEFAULT)
            begin
                for (int r = REG_INV_DX_SQ; r <= REG_LID; r++)
                    reg_access(1'b0, r, '0);

                // corner cases under the reset settings: clipping both ways, lid, spare codes
                send_node(OP_LAPLACIAN, node_of('0, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
                send_node(OP_LAPLACIAN, node_of(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                                '0, '0, '0, '0, '0), 1'b0);
                send_node(OP_LAPLACIAN, node_of(Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                                Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX), 1'b0);
                send_node(OP_LAPLACIAN, node_of(Q_ONE, '0, '1, Q_ONE, '0,
                                                '1, '1, '1, '1, '1), 1'b0);
                send_node(OP_ADVANCE, node_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                              Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0);
                send_node(OP_ADVANCE, node_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                              Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b0);
                send_node(OP_ADVANCE, node_of(Q_ONE, '1, Q_ONE, '0, Q_MAX,
                                              '1, Q_MIN, Q_MAX, Q_ONE, '0), 1'b0);
                send_node(OP_XWALL, node_of(Q_MAX, '0, '0, '0, Q_MIN,
                                            '0, '0, '0, '0, '0), 1'b0);
                send_node(OP_XWALL, node_of(Q_MIN, '1, '1, '1, Q_MAX,
                                            '1, '1, '1, '1, '1), 1'b0);
                send_node(OP_YWALL, node_of('0, Q_MAX, Q_MIN, Q_MAX, '1,
                                            '0, '0, '0, '0, '0), 1'b0);
                send_node(OP_YWALL, node_of(Q_MAX, '0, '0, '0, Q_MIN,
                                            Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b0);
                send_node(OP_LID, node_of('0, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
                send_node(OP_LID, node_of(Q_MIN, '0, '0, '0, Q_MAX,
                                          '0, '0, '0, '0, '0), 1'b0);
                send_node(OP_LID, node_of(Q_MAX, '0, '0, '0, Q_MIN,
                                          '0, '0, '0, '0, '0), 1'b0);
                for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
                    send_node(OP_W'(op), node_of(Q_MAX, Q_MIN, '1, Q_ONE, Q_MAX,
                                                 Q_MIN, '1, Q_MAX, Q_MIN, '1), 1'b0);
                directed_sent = items_sent;
            end
            else
            begin
                // registers change only with the pipeline empty
                drain_results();
                for (int r = REG_INV_DX_SQ; r <= REG_LID; r++)
                begin
                    case (phase)
                        PHASE_TOP:    setting = Q_MAX;
                        PHASE_BOTTOM: setting = Q_MIN;
                        PHASE_ZERO:   setting = '0;
                        default:      setting = random_setting(r);
                    endcase
                    reg_access(1'b1, r, setting);
                    reg_access(1'b0, r, '0);
                end
                settings_used++;
            end

            // hold the result side off while items keep coming, so the input stalls
            if (phase == PHASE_TOP || phase == PHASES / 2)
            begin
                long_hold_req = 1'b1;
                repeat (HOLD_ITEMS) send_node(random_op(), random_node(), 1'b1);
            end

            repeat (PHASE_ITEMS) send_node(random_op(), random_node(), 1'b0);
        end

        drain_results();
        repeat (3 * NUM_STAGES) @(posedge clk);

        $display("covered %0d items (%0d directed) under %0d register settings",
                 items_sent, directed_sent, settings_used);
        $display("checked %0d node results, %0d of them clipped", results_checked, saturated_seen);
        if (fail_count == 0)
            $display("vorticity_stencil_node_update_unit regression: pass");
        else
            $display("vorticity_stencil_node_update_unit regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/vsnu_pkg.sv
rtl/vsnu_datapath.sv
rtl/vorticity_stencil_node_update_unit.sv
tb/vsnu_stream_checker.sv
tb/tb_top.sv
